### hdl/clt_pkg.sv
// ============================================================================
// clt_pkg
// Shared types and constants for the character LCD terminal command queue.
// ============================================================================
package clt_pkg;

    // Configuration register indexes.
    typedef logic [0:0] t_cfg_idx;
    localparam t_cfg_idx CFG_DISPLAY_TYPE = 1'b0;
    localparam t_cfg_idx CFG_SCREEN_END   = 1'b1;

    // Display types.
    localparam logic [1:0] DT_GRAPHIC_16X4 = 2'd0;
    localparam logic [1:0] DT_TWO_LINE_16  = 2'd1;
    localparam logic [1:0] DT_FOUR_LINE_20 = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_BOUNDARY = 2'd2;

    // Text bytes and display commands.
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CMD_CLEAR    = 8'h01;
    localparam logic [7:0] CMD_DDRAM    = 8'h80;
    localparam logic [7:0] DDRAM_MASK   = 8'h7F;
    localparam logic [7:0] SCREEN_END_RESET = 8'd64;

    // One command request from the front to the back.
    typedef struct packed {
        logic       push;    // write one command into the queue
        logic       pop;     // read the oldest command out of the queue
        logic       finish;  // last request of an item: a result follows
        logic [1:0] status;
        logic       rs;
        logic [7:0] data;
    } t_op;

    // Line length of a display type; unused type behaves as graphic 16x4.
    function automatic logic [7:0] line_len(input logic [1:0] dtype);
        logic [7:0] len;
        len = (dtype == DT_FOUR_LINE_20) ? 8'h14 : 8'h10;
        return len;
    endfunction

    // DDRAM start address of a row for a display type.
    function automatic logic [7:0] row_addr(input logic [1:0] dtype, input logic [1:0] row);
        logic [7:0] a;
        a = 8'h00;
        unique case (dtype)
            DT_TWO_LINE_16: begin
                a = (row == 2'd1) ? 8'h40 : 8'h00;
            end
            DT_FOUR_LINE_20: begin
                unique case (row)
                    2'd0: a = 8'h00;
                    2'd1: a = 8'h40;
                    2'd2: a = 8'h14;
                    default: a = 8'h54;
                endcase
            end
            default: begin
                unique case (row)
                    2'd0: a = 8'h00;
                    2'd1: a = 8'h10;
                    2'd2: a = 8'h08;
                    default: a = 8'h18;
                endcase
            end
        endcase
        return a;
    endfunction

endpackage

### hdl/clt_in_if.sv
// ============================================================================
// clt_in_if
// Input channel: one text byte or one tick per request.
// ============================================================================
interface clt_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] char_code;

    modport source (output valid, output mode, output char_code, input ready);
    modport sink   (input valid, input mode, input char_code, output ready);
endinterface

### hdl/clt_out_if.sv
// ============================================================================
// clt_out_if
// Output channel: one result per input request.
// ============================================================================
interface clt_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic       port_valid;
    logic       port_rs;
    logic [7:0] port_data;

    modport source (output valid, output status, output port_valid, output port_rs,
                    output port_data, input ready);
    modport sink   (input valid, input status, input port_valid, input port_rs,
                    input port_data, output ready);
endinterface

### hdl/clt_ram.sv
// ============================================================================
// clt_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module clt_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port; read data holds without a read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/clt_front.sv
// ============================================================================
// clt_front
// Terminal front end: keeps the cursor, the newline flag and the logical
// queue fill, and turns each request into one or more command requests.
// ============================================================================
module clt_front #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  clt_pkg::t_cfg_idx i_cfg_idx,
    input  logic [7:0]        i_cfg_data,
    clt_in_if.sink            i_in,
    output logic              o_op_valid,
    output clt_pkg::t_op      o_op,
    input  logic              i_op_ready
);
    import clt_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] CNT_FULL = PTR_W'(QUEUE_DEPTH - 1);

    typedef enum logic [1:0] {
        STG_ADDR,
        STG_CLEAR,
        STG_CHAR
    } t_stage;

    logic [1:0]       r_display_type;
    logic [7:0]       r_screen_end;
    logic [7:0]       r_cursor;
    logic             r_nlp;
    logic [PTR_W-1:0] r_count;
    logic             r_busy;
    t_stage           r_stage;
    logic [7:0]       r_ch;

    logic [7:0]       n_cursor;
    logic             n_nlp;
    logic [PTR_W-1:0] n_count;
    t_stage           n_stage;

    t_op              w_op;
    t_stage           w_stg;
    logic [7:0]       w_ch;
    logic             w_tick;
    logic             w_used;
    logic             w_done;
    logic             w_full;
    logic [7:0]       w_len;
    logic [7:0]       w_mask;
    logic             w_fire;

    assign w_len  = line_len(r_display_type);
    assign w_mask = w_len - 8'd1;
    assign w_full = (r_count == CNT_FULL);
    assign w_stg  = r_busy ? r_stage : STG_ADDR;
    assign w_ch   = r_busy ? r_ch : i_in.char_code;
    assign w_tick = !r_busy && i_in.mode;

    // One step of the terminal: at most one queue write per cycle, the item
    // continues in a later cycle if it needs another write.
    always_comb begin
        n_cursor = r_cursor;
        n_nlp    = r_nlp;
        n_count  = r_count;
        n_stage  = STG_ADDR;
        w_op     = '0;
        w_used   = 1'b0;
        w_done   = 1'b0;
        if (w_tick) begin
            w_op.pop    = (r_count != '0);
            w_op.finish = 1'b1;
            w_op.status = ST_OK;
            if (r_count != '0) begin
                n_count = r_count - PTR_W'(1);
            end
        end else begin
            // Pending line start: set the DDRAM address of the cursor row.
            if (w_stg == STG_ADDR && r_nlp) begin
                if (w_full) begin
                    w_op.finish = 1'b1;
                    w_op.status = ST_FULL;
                    w_done      = 1'b1;
                end else begin
                    w_op.push = 1'b1;
                    w_op.rs   = 1'b0;
                    w_op.data = CMD_DDRAM | (row_addr(r_display_type, r_cursor[5:4])
                                             & DDRAM_MASK);
                    n_nlp     = 1'b0;
                    n_count   = r_count + PTR_W'(1);
                    w_used    = 1'b1;
                end
            end
            // Screen end: clear the display and home the cursor.
            if (!w_done && w_stg != STG_CHAR && r_cursor == r_screen_end) begin
                if (w_used) begin
                    w_done  = 1'b1;
                    n_stage = STG_CLEAR;
                end else if (w_full) begin
                    w_op.finish = 1'b1;
                    w_op.status = ST_FULL;
                    w_done      = 1'b1;
                end else begin
                    w_op.push = 1'b1;
                    w_op.rs   = 1'b0;
                    w_op.data = CMD_CLEAR;
                    n_cursor  = 8'd0;
                    n_count   = r_count + PTR_W'(1);
                    w_used    = 1'b1;
                end
            end
            // The byte itself.
            if (!w_done) begin
                if (w_ch == CH_NEWLINE) begin
                    n_cursor = (n_cursor & ~w_mask) + w_len;
                end else if (w_ch == CH_BACKSPACE) begin
                    n_cursor = n_cursor - 8'd1;
                end else if (w_used) begin
                    w_done  = 1'b1;
                    n_stage = STG_CHAR;
                end else if (w_full) begin
                    w_op.finish = 1'b1;
                    w_op.status = ST_FULL;
                    w_done      = 1'b1;
                end else begin
                    w_op.push = 1'b1;
                    w_op.rs   = 1'b1;
                    w_op.data = w_ch;
                    n_cursor  = n_cursor + 8'd1;
                    n_count   = r_count + PTR_W'(1);
                end
            end
            // Line boundary check closes the item.
            if (!w_done) begin
                w_op.finish = 1'b1;
                if ((n_cursor & w_mask) == 8'd0) begin
                    n_nlp       = 1'b1;
                    w_op.status = ST_BOUNDARY;
                end else begin
                    w_op.status = ST_OK;
                end
            end
        end
    end

    assign o_op_valid = r_busy || i_in.valid;
    assign o_op       = w_op;
    assign i_in.ready = !r_busy && i_op_ready;
    assign w_fire     = o_op_valid && i_op_ready;

    // Terminal state, item sequencing and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_display_type <= DT_GRAPHIC_16X4;
            r_screen_end   <= SCREEN_END_RESET;
            r_cursor       <= 8'd0;
            r_nlp          <= 1'b0;
            r_count        <= '0;
            r_busy         <= 1'b0;
            r_stage        <= STG_ADDR;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_DISPLAY_TYPE: r_display_type <= i_cfg_data[1:0];
                    CFG_SCREEN_END:   r_screen_end   <= i_cfg_data;
                    default:          r_screen_end   <= r_screen_end;
                endcase
            end
            if (w_fire) begin
                r_cursor <= n_cursor;
                r_nlp    <= n_nlp;
                r_count  <= n_count;
                r_busy   <= !w_op.finish;
                r_stage  <= n_stage;
            end
        end
    end

    // Byte of an item that needs more than one command request.
    always_ff @(posedge i_clk) begin
        if (w_fire && !r_busy) begin
            r_ch <= i_in.char_code;
        end
    end

endmodule

### hdl/clt_op_fifo.sv
// ============================================================================
// clt_op_fifo
// Two-entry queue of command requests between the front and the back.
// ============================================================================
module clt_op_fifo (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    input  clt_pkg::t_op i_in_op,
    output logic         o_in_ready,
    output logic         o_out_valid,
    output clt_pkg::t_op o_out_op,
    input  logic         i_out_ready
);
    import clt_pkg::*;

    t_op        r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;

    assign o_in_ready  = (r_cnt != 2'd2);
    assign o_out_valid = (r_cnt != 2'd0);
    assign o_out_op    = r_mem[r_rd];
    assign w_push      = i_in_valid && o_in_ready;
    assign w_pop       = o_out_valid && i_out_ready;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr <= !r_wr;
            end
            if (w_pop) begin
                r_rd <= !r_rd;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_in_op;
        end
    end

endmodule

### hdl/clt_back.sv
// ============================================================================
// clt_back
// Back end: carries out queue writes and reads on the command RAM and
// registers one result per item on the output channel.
// ============================================================================
module clt_back #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_op_valid,
    input  clt_pkg::t_op i_op,
    output logic         o_op_ready,
    clt_out_if.source    o_out
);
    import clt_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    logic [PTR_W-1:0] r_head;
    logic [PTR_W-1:0] r_tail;
    logic             r_s1_valid;
    logic             r_s1_pop;
    logic [1:0]       r_s1_status;
    logic             r_out_valid;
    logic [1:0]       r_out_status;
    logic             r_out_pv;
    logic             r_out_rs;
    logic [7:0]       r_out_data;

    logic [PTR_W-1:0] w_head_nxt;
    logic [PTR_W-1:0] w_tail_nxt;
    logic             w_out_adv;
    logic             w_s1_adv;
    logic             w_s1_free;
    logic             w_fire;
    logic [8:0]       w_rdata;

    assign w_head_nxt = (r_head == PTR_LAST) ? '0 : r_head + PTR_W'(1);
    assign w_tail_nxt = (r_tail == PTR_LAST) ? '0 : r_tail + PTR_W'(1);

    assign w_out_adv  = !r_out_valid || o_out.ready;
    assign w_s1_adv   = r_s1_valid && w_out_adv;
    assign w_s1_free  = !r_s1_valid || w_out_adv;
    assign o_op_ready = !i_op.finish || w_s1_free;
    assign w_fire     = i_op_valid && o_op_ready;

    // Command queue storage: rs in bit 8, byte in bits 7..0.
    clt_ram #(
        .WIDTH (9),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_fire && i_op.push),
        .i_waddr (w_head_nxt),
        .i_wdata ({i_op.rs, i_op.data}),
        .i_re    (w_fire && i_op.pop),
        .i_raddr (w_tail_nxt),
        .o_rdata (w_rdata)
    );

    // Queue pointers, read stage and output register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_fire && i_op.push) begin
                r_head <= w_head_nxt;
            end
            if (w_fire && i_op.pop) begin
                r_tail <= w_tail_nxt;
            end
            if (w_fire && i_op.finish) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (w_fire && i_op.finish) begin
            r_s1_pop    <= i_op.pop;
            r_s1_status <= i_op.status;
        end
        if (w_s1_adv) begin
            r_out_status <= r_s1_status;
            r_out_pv     <= r_s1_pop;
            r_out_rs     <= r_s1_pop && w_rdata[8];
            r_out_data   <= r_s1_pop ? w_rdata[7:0] : 8'd0;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.status     = r_out_status;
    assign o_out.port_valid = r_out_pv;
    assign o_out.port_rs    = r_out_rs;
    assign o_out.port_data  = r_out_data;

endmodule

### hdl/char_lcd_terminal_cmd_queue_core.sv
// Path: an accepted request goes through the request queue, the read stage
// and the output register; a multi-command text byte sends one request per command.
// Throughput: one request per cycle while the request queue has room; a text byte
// that queues two or three commands holds the input, one command RAM write each.
// Reset: synchronous, active low; clears cursor, newline flag, queue
// pointers and configuration. Queue entries are not cleared; no clear pass.
// ============================================================================
// char_lcd_terminal_cmd_queue_core
// Text terminal for a character LCD: text bytes become display commands in
// a ring queue, and each tick drains one command, if any, to the display port.
// ============================================================================
module char_lcd_terminal_cmd_queue_core #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  clt_pkg::t_cfg_idx i_cfg_idx,
    input  logic [7:0]        i_cfg_data,
    clt_in_if.sink            i_in,
    clt_out_if.source         o_out
);
    import clt_pkg::*;

    logic w_fe_op_valid;
    t_op  w_fe_op;
    logic w_fe_op_ready;
    logic w_be_op_valid;
    t_op  w_be_op;
    logic w_be_op_ready;

    // Front end: terminal state and command generation.
    clt_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .o_op_valid (w_fe_op_valid),
        .o_op       (w_fe_op),
        .i_op_ready (w_fe_op_ready)
    );

    // Request queue between front and back.
    clt_op_fifo u_op_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (w_fe_op_valid),
        .i_in_op     (w_fe_op),
        .o_in_ready  (w_fe_op_ready),
        .o_out_valid (w_be_op_valid),
        .o_out_op    (w_be_op),
        .i_out_ready (w_be_op_ready)
    );

    // Back end: command RAM and result register.
    clt_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (w_be_op_valid),
        .i_op       (w_be_op),
        .o_op_ready (w_be_op_ready),
        .o_out      (o_out)
    );

`ifndef NO_ASSERTIONS
    // An accepted request always hands its first command request over.
    a_accept_hands_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |-> (w_fe_op_valid && w_fe_op_ready))
        else $error("accepted request did not reach the request queue");

    // A request never both writes and reads the command queue.
    a_push_pop_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_be_op_valid |-> !(w_be_op.push && w_be_op.pop))
        else $error("command request both writes and reads the queue");

    // A drained command is reported with an ok status.
    a_drain_status_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.port_valid) |-> (o_out.status == ST_OK))
        else $error("drained command with a non-ok status");
`endif

endmodule

### sim/clt_terminal_sb_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// clt_terminal_sb_pkg
// Scoreboard for the character LCD terminal command queue. It predicts the
// result of every accepted request and checks each result against the oldest
// prediction.
// ============================================================================
package clt_terminal_sb_pkg;
    import clt_pkg::*;

    localparam int SB_QUEUE_DEPTH = 16;

    // Request modes.
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_TICK  = 1'b1;

    // Display type code that the block treats as the graphic 16x4 type.
    localparam logic [1:0] DT_UNUSED = 2'd3;

    localparam int REPORT_LIMIT = 10;

    class terminal_scoreboard;
        typedef struct packed {
            logic [1:0] status;
            logic       port_valid;
            logic       port_rs;
            logic [7:0] port_data;
        } t_result;

        // Shadow of the configuration and of the terminal state.
        logic [1:0] dtype;
        logic [7:0] scr_end;
        logic [7:0] cursor;
        logic       nl_pending;
        int         head;
        int         tail;
        logic [8:0] cmds[SB_QUEUE_DEPTH];

        t_result expected[$];

        int n_writes;
        int n_ticks;
        int n_full;
        int n_boundary;
        int n_clear;
        int n_drained;
        int n_empty;
        int n_checked;
        int n_fail;

        function new();
            reset_state();
        endfunction

        function void reset_state();
            dtype      = DT_GRAPHIC_16X4;
            scr_end    = SCREEN_END_RESET;
            cursor     = 8'd0;
            nl_pending = 1'b0;
            head       = 0;
            tail       = 0;
            expected.delete();
        endfunction

        function void set_register(t_cfg_idx idx, logic [7:0] data);
            if (idx == CFG_DISPLAY_TYPE) begin
                dtype = data[1:0];
            end else begin
                scr_end = data;
            end
        endfunction

        function int pending();
            return expected.size();
        endfunction

        // DDRAM address of the first cell of a row for the current type.
        function logic [7:0] row_start(logic [1:0] row);
            logic [7:0] starts[4];
            case (dtype)
                DT_TWO_LINE_16: begin
                    starts = '{8'h00, 8'h40, 8'h00, 8'h00};
                end
                DT_FOUR_LINE_20: begin
                    starts = '{8'h00, 8'h40, 8'h14, 8'h54};
                end
                default: begin
                    starts = '{8'h00, 8'h10, 8'h08, 8'h18};
                end
            endcase
            return starts[row];
        endfunction

        // Push one command; the ring keeps one slot free, so it refuses when full.
        function bit queue_cmd(logic rs, logic [7:0] byte_val);
            int nxt;
            nxt = (head + 1) % SB_QUEUE_DEPTH;
            if (nxt == tail) begin
                return 1'b0;
            end
            head = nxt;
            cmds[head] = {rs, byte_val};
            return 1'b1;
        endfunction

        // Work out the result of one accepted request and queue it.
        function void note_request(logic mode, logic [7:0] ch);
            t_result    r;
            logic [7:0] len;
            logic [7:0] mask;
            bit         ok;
            r    = '0;
            len  = (dtype == DT_FOUR_LINE_20) ? 8'd20 : 8'd16;
            mask = len - 8'd1;
            ok   = 1'b1;

            if (mode == MODE_TICK) begin
                n_ticks++;
                if (head != tail) begin
                    tail = (tail + 1) % SB_QUEUE_DEPTH;
                    r.port_valid = 1'b1;
                    {r.port_rs, r.port_data} = cmds[tail];
                    n_drained++;
                end else begin
                    n_empty++;
                end
                expected.push_back(r);
                return;
            end

            n_writes++;
            // A pending line start goes out before anything else.
            if (nl_pending) begin
                ok = queue_cmd(1'b0, CMD_DDRAM | (row_start(cursor[5:4]) & DDRAM_MASK));
                if (ok) begin
                    nl_pending = 1'b0;
                end
            end
            // At the screen end the display is cleared and the cursor homed.
            if (ok && cursor == scr_end) begin
                ok = queue_cmd(1'b0, CMD_CLEAR);
                if (ok) begin
                    cursor = 8'd0;
                    n_clear++;
                end
            end
            if (ok) begin
                if (ch == CH_NEWLINE) begin
                    cursor = (cursor & ~mask) + len;
                end else if (ch == CH_BACKSPACE) begin
                    cursor = cursor - 8'd1;
                end else begin
                    ok = queue_cmd(1'b1, ch);
                    if (ok) begin
                        cursor = cursor + 8'd1;
                    end
                end
            end

            if (!ok) begin
                r.status = ST_FULL;
                n_full++;
            end else if ((cursor & mask) == 8'd0) begin
                nl_pending = 1'b1;
                r.status = ST_BOUNDARY;
                n_boundary++;
            end
            expected.push_back(r);
        endfunction

        function void report_failure(string msg);
            n_fail++;
            if (n_fail <= REPORT_LIMIT) begin
                $display("ERROR: %s", msg);
            end
        endfunction

        // Compare one accepted result with the oldest prediction.
        function void check_result(logic [1:0] status, logic port_valid, logic port_rs,
                                   logic [7:0] port_data);
            t_result exp_r;
            if (expected.size() == 0) begin
                report_failure($sformatf("result with nothing pending: status %0d valid %0b",
                                         status, port_valid));
                return;
            end
            exp_r = expected.pop_front();
            n_checked++;
            if (status !== exp_r.status || port_valid !== exp_r.port_valid ||
                port_rs !== exp_r.port_rs || port_data !== exp_r.port_data) begin
                report_failure($sformatf(
                    "result %0d: expected status %0d valid %0b rs %0b data %02h, got %0d %0b %0b %02h",
                    n_checked, exp_r.status, exp_r.port_valid, exp_r.port_rs, exp_r.port_data,
                    status, port_valid, port_rs, port_data));
            end
        endfunction
    endclass

endpackage

### sim/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Testbench for the character LCD terminal command queue. Text bytes and
// ticks are driven under several display types, screen ends and idle
// patterns; every result is checked against a scoreboard prediction.
// ============================================================================
module tb_top;
    import clt_pkg::*;
    import clt_terminal_sb_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 150;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_we;
    t_cfg_idx   i_cfg_idx;
    logic [7:0] i_cfg_data;

    clt_in_if  in_if ();
    clt_out_if out_if ();

    terminal_scoreboard sb = new();
    t_idle_mode idle_mode = IDLE_NONE;
    int hold_req  = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int cycles    = 0;

    char_lcd_terminal_cmd_queue_core #(
        .QUEUE_DEPTH(SB_QUEUE_DEPTH)
    ) i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_in      (in_if),
        .o_out     (out_if)
    );

    // 20 ns clock.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic bit sender_idles();
        case (idle_mode)
            IDLE_SENDER: return $urandom_range(0, 99) < 74;
            IDLE_BOTH:   return $urandom_range(0, 99) < 20;
            default:     return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stalls();
        case (idle_mode)
            IDLE_RECEIVER: return $urandom_range(0, 99) < 74;
            IDLE_BOTH:     return $urandom_range(0, 99) < 20;
            default:       return 1'b0;
        endcase
    endfunction

    // Result side: ready changes on the falling edge; a long hold-off is
    // started by bumping hold_req and counted down here.
    always @(negedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= !receiver_stalls();
        end
    end

    // Check every accepted result.
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            sb.check_result(out_if.status, out_if.port_valid, out_if.port_rs, out_if.port_data);
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Offer one request, with random gaps first, and hold it until accepted.
    // Entered and left at a falling edge.
    task automatic send_req(input logic mode, input logic [7:0] ch);
        while (sender_idles()) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.mode      <= mode;
        in_if.char_code <= ch;
        do begin
            @(posedge i_clk);
        end while (!in_if.ready);
        sb.note_request(mode, ch);
        @(negedge i_clk);
    endtask

    // Stop offering and wait until every predicted result has been checked.
    task automatic wait_drained();
        in_if.valid <= 1'b0;
        do begin
            @(negedge i_clk);
        end while (sb.pending() != 0);
    endtask

    // Bursts of requests; each burst has its own mix of writes and ticks so
    // the queue both fills up and runs dry.
    task automatic run_random(input int count);
        int         sent;
        int         burst;
        int         write_pct;
        int         pick;
        logic [7:0] ch;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(4, 32);
            case ($urandom_range(0, 3))
                0:       write_pct = 30;
                1:       write_pct = 50;
                2:       write_pct = 70;
                default: write_pct = 95;
            endcase
            for (int i = 0; i < burst && sent < count; i++) begin
                ch = 8'($urandom_range(0, 255));
                if ($urandom_range(0, 99) < write_pct) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 12) begin
                        ch = CH_NEWLINE;
                    end else if (pick < 22) begin
                        ch = CH_BACKSPACE;
                    end
                    send_req(MODE_WRITE, ch);
                end else begin
                    send_req(MODE_TICK, ch);
                end
                sent++;
            end
        end
    endtask

    // Drain, let the pipeline settle, then write both registers.
    task automatic run_phase(input logic [1:0] dtype, input logic [7:0] scr_end,
                             input t_idle_mode idle);
        logic [7:0] type_word;
        wait_drained();
        repeat (4) @(negedge i_clk);
        idle_mode = idle;
        type_word = {6'($urandom_range(0, 63)), dtype};
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_DISPLAY_TYPE;
        i_cfg_data <= type_word;
        sb.set_register(CFG_DISPLAY_TYPE, type_word);
        @(negedge i_clk);
        i_cfg_idx  <= CFG_SCREEN_END;
        i_cfg_data <= scr_end;
        sb.set_register(CFG_SCREEN_END, scr_end);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = CFG_DISPLAY_TYPE;
        i_cfg_data      = 8'd0;
        in_if.valid     = 1'b0;
        in_if.mode      = MODE_WRITE;
        in_if.char_code = 8'd0;
        out_if.ready    = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: tick on an empty queue, backspace wrapping below zero,
        // a newline onto a line boundary, then the pending address command
        // and the extreme bytes, then writes until the queue overflows.
        send_req(MODE_TICK, 8'hA5);
        send_req(MODE_WRITE, CH_BACKSPACE);
        send_req(MODE_WRITE, CH_NEWLINE);
        send_req(MODE_WRITE, 8'h00);
        send_req(MODE_WRITE, 8'hFF);
        for (int i = 0; i < 13; i++) begin
            send_req(MODE_WRITE, 8'h41 + 8'(i));
        end
        for (int i = 0; i < 4; i++) begin
            send_req(MODE_TICK, 8'h5A);
        end
        run_random(120);

        run_phase(DT_TWO_LINE_16, 8'd32, IDLE_NONE);
        run_random(140);

        // Mid-phase the sender pauses until every result is back.
        run_phase(DT_FOUR_LINE_20, 8'd255, IDLE_SENDER);
        run_random(70);
        wait_drained();
        run_random(70);

        run_phase(DT_UNUSED, 8'd0, IDLE_RECEIVER);
        run_random(140);

        run_phase(DT_GRAPHIC_16X4, 8'd16, IDLE_BOTH);
        run_random(140);

        // The receiver holds off while requests keep coming, so the block
        // backs up and stalls its input.
        run_phase(DT_FOUR_LINE_20, 8'd80, IDLE_NONE);
        hold_req++;
        run_random(140);

        run_phase(DT_TWO_LINE_16, 8'($urandom_range(1, 254)), IDLE_BOTH);
        run_random(140);

        wait_drained();
        repeat (8) @(negedge i_clk);

        $display("Covered %0d text bytes and %0d ticks across all display types and idle patterns.",
                 sb.n_writes, sb.n_ticks);
        $display("Saw %0d queue-full aborts, %0d line boundaries, %0d screen clears, %0d empty ticks.",
                 sb.n_full, sb.n_boundary, sb.n_clear, sb.n_empty);
        if (sb.n_fail == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d failures, %0d results outstanding", sb.n_fail, sb.pending());
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
